### hdl/fpm_pkg.sv
// Shared types and constants for the field pair merge frame indexer.
package fpm_pkg;

	// Depth of the result queue; two slots are kept free for a two-result item.
	localparam int Q_DEPTH = 4;

	// Configuration register indexes (byte address is 4 * index).
	localparam logic REG_MERGE_ENABLE = 1'b0;

	// One packet descriptor as taken from the input channel.
	typedef struct packed {
		logic [32:0] pts;
		logic [47:0] file_offset;
		logic [23:0] packet_size;
		logic        is_keyframe;
		logic [1:0]  frame_type;
		logic        field_coded;
		logic        bottom_field;
		logic [15:0] field_frame_num;
		logic        end_of_stream;
	} item_t;

	// One frame record as sent on the output channel.
	typedef struct packed {
		logic [31:0] frame_index;
		logic [31:0] gop_index;
		logic [32:0] out_pts;
		logic [47:0] out_offset;
		logic [24:0] out_size;
		logic [1:0]  out_type;
		logic        out_keyframe;
		logic [31:0] raw_index;
		logic        fields_merged;
		logic        last;
	} res_t;

	// Results produced by one item: count (0..2), first and second record.
	typedef struct packed {
		logic [1:0] n;
		res_t       r0;
		res_t       r1;
	} pair_out_t;

endpackage

### hdl/fpm_pair.sv
// Field pairing, pending field register and frame/GOP/raw counters.
module fpm_pair #(
	parameter int FRAME_NUM_BITS = 16,
	parameter int COUNTER_BITS   = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  fpm_pkg::item_t    item,
	input  logic              go,
	input  logic              merge_enable,
	output fpm_pkg::pair_out_t res
);
	import fpm_pkg::*;

	localparam logic [COUNTER_BITS-1:0] CNT_MAX = '1;

	// pending top field
	logic                      pend_v_q;
	logic [32:0]               pend_pts_q;
	logic [47:0]               pend_off_q;
	logic [23:0]               pend_size_q;
	logic                      pend_key_q;
	logic [1:0]                pend_type_q;
	logic [FRAME_NUM_BITS-1:0] pend_fnum_q;
	logic [COUNTER_BITS-1:0]   pend_raw_q;

	// running counters
	logic [COUNTER_BITS-1:0] raw_cnt_q;
	logic [COUNTER_BITS-1:0] frame_cnt_q;
	logic [COUNTER_BITS-1:0] gop_cnt_q;

	logic                    match;
	logic                    store;
	logic                    a_val;
	logic                    b_val;
	logic [24:0]             size_a;
	logic [COUNTER_BITS-1:0] frame_a_inc;
	logic [COUNTER_BITS-1:0] frame_b;
	logic [COUNTER_BITS-1:0] frame_b_inc;
	logic [COUNTER_BITS-1:0] frame_next;
	logic [COUNTER_BITS-1:0] gop_a;
	logic [COUNTER_BITS-1:0] gop_base;
	logic [COUNTER_BITS-1:0] gop_b;
	logic [COUNTER_BITS-1:0] gop_next;
	logic [COUNTER_BITS-1:0] raw_next;
	res_t                    res_a;
	res_t                    res_b;

	// pairing decision
	always_comb begin
		match = merge_enable & pend_v_q & item.field_coded & item.bottom_field &
			(item.field_frame_num[FRAME_NUM_BITS-1:0] == pend_fnum_q);
		store = merge_enable & item.field_coded & ~item.bottom_field & ~item.end_of_stream;
		a_val = pend_v_q;
		b_val = ~match & ~store;
		size_a = match ? ({1'b0, pend_size_q} + {1'b0, item.packet_size})
			: {1'b0, pend_size_q};
	end

	// saturating counters, up to two frames per item
	always_comb begin
		raw_next    = (raw_cnt_q == CNT_MAX) ? raw_cnt_q : raw_cnt_q + 1'b1;
		frame_a_inc = (frame_cnt_q == CNT_MAX) ? frame_cnt_q : frame_cnt_q + 1'b1;
		frame_b     = a_val ? frame_a_inc : frame_cnt_q;
		frame_b_inc = (frame_b == CNT_MAX) ? frame_b : frame_b + 1'b1;
		if (b_val) begin
			frame_next = frame_b_inc;
		end else if (a_val) begin
			frame_next = frame_a_inc;
		end else begin
			frame_next = frame_cnt_q;
		end

		gop_a = gop_cnt_q;
		if ((frame_cnt_q != '0) && pend_key_q && (gop_cnt_q != CNT_MAX))
			gop_a = gop_cnt_q + 1'b1;
		gop_base = a_val ? gop_a : gop_cnt_q;
		gop_b = gop_base;
		if ((frame_b != '0) && item.is_keyframe && (gop_base != CNT_MAX))
			gop_b = gop_base + 1'b1;
		gop_next = b_val ? gop_b : gop_base;
	end

	// result records
	always_comb begin
		res_a.frame_index   = 32'(frame_cnt_q);
		res_a.gop_index     = 32'(gop_a);
		res_a.out_pts       = pend_pts_q;
		res_a.out_offset    = pend_off_q;
		res_a.out_size      = size_a;
		res_a.out_type      = pend_type_q;
		res_a.out_keyframe  = pend_key_q;
		res_a.raw_index     = 32'(pend_raw_q);
		res_a.fields_merged = match;
		res_a.last          = ~b_val;

		res_b.frame_index   = 32'(frame_b);
		res_b.gop_index     = 32'(gop_b);
		res_b.out_pts       = item.pts;
		res_b.out_offset    = item.file_offset;
		res_b.out_size      = {1'b0, item.packet_size};
		res_b.out_type      = item.frame_type;
		res_b.out_keyframe  = item.is_keyframe;
		res_b.raw_index     = 32'(raw_cnt_q);
		res_b.fields_merged = 1'b0;
		res_b.last          = 1'b1;

		res.n  = {a_val & b_val, a_val ^ b_val};
		res.r0 = a_val ? res_a : res_b;
		res.r1 = res_b;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q    <= 1'b0;
			raw_cnt_q   <= '0;
			frame_cnt_q <= '0;
			gop_cnt_q   <= '0;
		end else if (go) begin
			pend_v_q    <= store;
			raw_cnt_q   <= raw_next;
			frame_cnt_q <= frame_next;
			gop_cnt_q   <= gop_next;
		end
	end

	// pending field payload, loaded when a top field is held
	always_ff @(posedge clk) begin
		if (go && store) begin
			pend_pts_q  <= item.pts;
			pend_off_q  <= item.file_offset;
			pend_size_q <= item.packet_size;
			pend_key_q  <= item.is_keyframe;
			pend_type_q <= item.frame_type;
			pend_fnum_q <= item.field_frame_num[FRAME_NUM_BITS-1:0];
			pend_raw_q  <= raw_cnt_q;
		end
	end

endmodule

### hdl/fpm_outq.sv
// Small result queue: takes up to two records a cycle, sends one a cycle while out_ready is high.
module fpm_outq (
	input  logic               clk,
	input  logic               arst_n,
	input  fpm_pkg::pair_out_t push,
	input  logic               push_en,
	output logic               room,
	output logic               out_valid,
	input  logic               out_ready,
	output fpm_pkg::res_t      out_data
);
	import fpm_pkg::*;

	localparam int PTR_W = $clog2(Q_DEPTH);
	localparam logic [PTR_W:0] ROOM_MAX = (PTR_W + 1)'(Q_DEPTH - 2);

	res_t             mem_q [Q_DEPTH];
	logic [PTR_W-1:0] wp_q;
	logic [PTR_W-1:0] rp_q;
	logic [PTR_W:0]   cnt_q;
	logic [1:0]       n_eff;
	logic             pop;
	logic [PTR_W-1:0] wp1;

	always_comb begin
		n_eff     = push_en ? push.n : 2'd0;
		out_valid = (cnt_q != '0);
		pop       = out_valid & out_ready;
		room      = (cnt_q <= ROOM_MAX);
		wp1       = wp_q + 1'b1;
		out_data  = mem_q[rp_q];
	end

	// storage writes
	always_ff @(posedge clk) begin
		for (int i = 0; i < Q_DEPTH; i++) begin
			if ((n_eff != 2'd0) && (PTR_W'(i) == wp_q))
				mem_q[i] <= push.r0;
			if ((n_eff == 2'd2) && (PTR_W'(i) == wp1))
				mem_q[i] <= push.r1;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + PTR_W'(n_eff);
			if (pop)
				rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (PTR_W + 1)'(n_eff) - (PTR_W + 1)'(pop);
		end
	end

endmodule

### hdl/field_pair_merge_frame_indexer_core.sv
// Top level of the field pair merge frame indexer.
//
//   channel | direction | handshake          | beat
//   in      | input     | in_valid/in_ready  | one packet descriptor
//   out     | output    | out_valid/out_ready| one frame record
//   cfg     | input     | APB psel/penable   | merge_enable register at 0x0
//
// One descriptor is accepted per cycle while the queue has room. It sits in
// the input register, then its zero, one or two frame records enter a
// four-entry queue, and out_valid rises once a record is written there.
// An item yielding two records occupies the output for two beats, so the
// queue and its two-free-slots rule set the sustained rate under backpressure.
// Reset clears the pending field, all counters and the queue; merge_enable
// resets to 1.
module field_pair_merge_frame_indexer_core #(
	parameter int FRAME_NUM_BITS = 16,
	parameter int COUNTER_BITS   = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	// packet descriptors
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [32:0] pts,
	input  logic [47:0] file_offset,
	input  logic [23:0] packet_size,
	input  logic        is_keyframe,
	input  logic [1:0]  frame_type,
	input  logic        field_coded,
	input  logic        bottom_field,
	input  logic [15:0] field_frame_num,
	input  logic        end_of_stream,
	// frame records
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] frame_index,
	output logic [31:0] gop_index,
	output logic [32:0] out_pts,
	output logic [47:0] out_offset,
	output logic [24:0] out_size,
	output logic [1:0]  out_type,
	output logic        out_keyframe,
	output logic [31:0] raw_index,
	output logic        fields_merged,
	output logic        last,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import fpm_pkg::*;

	logic      merge_q;
	logic      v_s1;
	item_t     item_s1;
	logic      room;
	logic      go;
	logic      in_acc;
	pair_out_t pair_res;
	res_t      out_data;

	// config register
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			merge_q <= 1'b1;
		end else if (psel && penable && pwrite && (paddr[2] == REG_MERGE_ENABLE)) begin
			merge_q <= pwdata[0];
		end
	end
	assign prdata = (paddr[2] == REG_MERGE_ENABLE) ? {31'd0, merge_q} : 32'd0;

	// input register
	assign go       = v_s1 & room;
	assign in_ready = ~v_s1 | go;
	assign in_acc   = in_valid & in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_acc) begin
			v_s1 <= 1'b1;
		end else if (go) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			item_s1.pts             <= pts;
			item_s1.file_offset     <= file_offset;
			item_s1.packet_size     <= packet_size;
			item_s1.is_keyframe     <= is_keyframe;
			item_s1.frame_type      <= frame_type;
			item_s1.field_coded     <= field_coded;
			item_s1.bottom_field    <= bottom_field;
			item_s1.field_frame_num <= field_frame_num;
			item_s1.end_of_stream   <= end_of_stream;
		end
	end

	// pairing and indexing
	fpm_pair #(
		.FRAME_NUM_BITS(FRAME_NUM_BITS),
		.COUNTER_BITS  (COUNTER_BITS)
	) u_pair (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (item_s1),
		.go          (go),
		.merge_enable(merge_q),
		.res         (pair_res)
	);

	// result queue
	fpm_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (pair_res),
		.push_en  (go),
		.room     (room),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	assign frame_index   = out_data.frame_index;
	assign gop_index     = out_data.gop_index;
	assign out_pts       = out_data.out_pts;
	assign out_offset    = out_data.out_offset;
	assign out_size      = out_data.out_size;
	assign out_type      = out_data.out_type;
	assign out_keyframe  = out_data.out_keyframe;
	assign raw_index     = out_data.raw_index;
	assign fields_merged = out_data.fields_merged;
	assign last          = out_data.last;

endmodule

### sim/tb_top.sv
// Self-checking testbench for the field pair merge frame indexer core.
`timescale 1ns / 1ps

module tb_top;
	import fpm_pkg::*;

	localparam int FN_BITS = 16;
	localparam int CNT_BITS = 32;
	localparam logic [31:0] CNT_MAX = 32'((64'd1 << CNT_BITS) - 64'd1);
	localparam logic [15:0] FN_MASK = 16'((32'd1 << FN_BITS) - 32'd1);
	localparam logic [2:0] MERGE_EN_ADDR = 3'(4 * REG_MERGE_ENABLE);
	// input register plus result queue; a stored top field yields nothing
	localparam int SETTLE_CYCLES = 8;
	localparam int DRAIN_CYCLES = 20;
	localparam int unsigned CYCLE_LIMIT = 400000;

	// receiver backpressure patterns
	typedef enum int {RX_FREE, RX_COIN, RX_SLOW, RX_LIGHT} rx_mode_e;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// packet channel
	logic in_valid = 1'b0;
	logic in_ready;
	item_t in_pkt = '0;

	// frame channel
	logic out_valid;
	logic out_ready = 1'b0;
	logic [31:0] frame_index;
	logic [31:0] gop_index;
	logic [32:0] out_pts;
	logic [47:0] out_offset;
	logic [24:0] out_size;
	logic [1:0] out_type;
	logic out_keyframe;
	logic [31:0] raw_index;
	logic fields_merged;
	logic last;

	// register port
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	int errors = 0;
	int unsigned cycles = 0;

	// predictor state
	logic merge_on = 1'b1;
	logic held_valid = 1'b0;
	item_t held_top = '0;
	logic [31:0] held_raw = '0;
	logic [31:0] raw_count = '0;
	logic [31:0] frame_count = '0;
	logic [31:0] gop_count = '0;

	item_t pkt_q[$];
	res_t frame_q[$];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	field_pair_merge_frame_indexer_core #(
		.FRAME_NUM_BITS(FN_BITS),
		.COUNTER_BITS(CNT_BITS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.pts(in_pkt.pts),
		.file_offset(in_pkt.file_offset),
		.packet_size(in_pkt.packet_size),
		.is_keyframe(in_pkt.is_keyframe),
		.frame_type(in_pkt.frame_type),
		.field_coded(in_pkt.field_coded),
		.bottom_field(in_pkt.bottom_field),
		.field_frame_num(in_pkt.field_frame_num),
		.end_of_stream(in_pkt.end_of_stream),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.frame_index(frame_index),
		.gop_index(gop_index),
		.out_pts(out_pts),
		.out_offset(out_offset),
		.out_size(out_size),
		.out_type(out_type),
		.out_keyframe(out_keyframe),
		.raw_index(raw_index),
		.fields_merged(fields_merged),
		.last(last),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	function automatic logic [31:0] sat_inc(input logic [31:0] v);
		return (v >= CNT_MAX) ? CNT_MAX : v + 32'd1;
	endfunction

	// Queue one frame record; GOP index steps on every keyframe but the first frame.
	function automatic void push_frame(input logic [32:0] p, input logic [47:0] o,
			input logic [24:0] sz, input logic key, input logic [1:0] typ,
			input logic [31:0] raw, input logic merged);
		res_t r;
		if (frame_count != 32'd0 && key)
			gop_count = sat_inc(gop_count);
		r.frame_index = frame_count;
		r.gop_index = gop_count;
		r.out_pts = p;
		r.out_offset = o;
		r.out_size = sz;
		r.out_type = typ;
		r.out_keyframe = key;
		r.raw_index = raw;
		r.fields_merged = merged;
		r.last = 1'b0;
		frame_q.push_back(r);
		frame_count = sat_inc(frame_count);
	endfunction

	// Expected frames for one accepted packet: pair, flush, hold or pass.
	function automatic void predict_frames(input item_t it);
		logic [31:0] raw;
		int n0;
		res_t r;
		raw = raw_count;
		raw_count = sat_inc(raw_count);
		n0 = frame_q.size();
		if (merge_on && held_valid && it.field_coded && it.bottom_field &&
				((it.field_frame_num ^ held_top.field_frame_num) & FN_MASK) == '0) begin
			push_frame(held_top.pts, held_top.file_offset,
				{1'b0, held_top.packet_size} + {1'b0, it.packet_size},
				held_top.is_keyframe, held_top.frame_type, held_raw, 1'b1);
			held_valid = 1'b0;
		end else begin
			if (held_valid) begin
				push_frame(held_top.pts, held_top.file_offset, {1'b0, held_top.packet_size},
					held_top.is_keyframe, held_top.frame_type, held_raw, 1'b0);
				held_valid = 1'b0;
			end
			if (merge_on && it.field_coded && !it.bottom_field && !it.end_of_stream) begin
				held_valid = 1'b1;
				held_top = it;
				held_raw = raw;
			end else begin
				push_frame(it.pts, it.file_offset, {1'b0, it.packet_size},
					it.is_keyframe, it.frame_type, raw, 1'b0);
			end
		end
		if (frame_q.size() > n0) begin
			r = frame_q.pop_back();
			r.last = 1'b1;
			frame_q.push_back(r);
		end
	endfunction

	// Wide random value, biased toward all zeros and all ones.
	function automatic logic [63:0] rnd_wide();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// Packet with the given field role and random content.
	function automatic item_t pkt(input logic fc, input logic bot, input logic [15:0] fn,
			input logic eos);
		item_t p;
		logic [63:0] w;
		w = rnd_wide();
		p.pts = w[32:0];
		w = rnd_wide();
		p.file_offset = w[47:0];
		w = rnd_wide();
		p.packet_size = w[23:0];
		p.is_keyframe = ($urandom_range(0, 4) == 0);
		p.frame_type = ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
		p.field_coded = fc;
		p.bottom_field = bot;
		p.field_frame_num = fn;
		p.end_of_stream = eos;
		return p;
	endfunction

	// Mostly well-formed top/bottom pairs, with broken pairs and other packets mixed in.
	task automatic gen_stream(input int n);
		int k;
		int r;
		logic [15:0] fn;
		k = 0;
		while (k < n) begin
			r = $urandom_range(0, 99);
			fn = 16'($urandom);
			if (r < 55) begin
				pkt_q.push_back(pkt(1'b1, 1'b0, fn, 1'b0));
				pkt_q.push_back(pkt(1'b1, 1'b1, fn, $urandom_range(0, 19) == 0));
				k += 2;
			end else if (r < 65) begin
				// bottom differs from its top in one frame number bit
				pkt_q.push_back(pkt(1'b1, 1'b0, fn, 1'b0));
				pkt_q.push_back(pkt(1'b1, 1'b1, fn ^ (16'd1 << $urandom_range(0, 15)), 1'b0));
				k += 2;
			end else if (r < 80) begin
				pkt_q.push_back(pkt(1'b0, 1'($urandom_range(0, 1)), fn,
					$urandom_range(0, 29) == 0));
				k++;
			end else if (r < 88) begin
				pkt_q.push_back(pkt(1'b1, 1'b0, fn, 1'b0));
				k++;
			end else if (r < 92) begin
				pkt_q.push_back(pkt(1'b1, 1'b0, fn, 1'b1));
				k++;
			end else if (r < 96) begin
				pkt_q.push_back(pkt(1'b1, 1'b1, fn, 1'b0));
				k++;
			end else begin
				pkt_q.push_back(pkt(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), fn,
					1'($urandom_range(0, 1))));
				k++;
			end
		end
	endtask

	// Wait until every packet is taken and every frame has come out.
	task automatic wait_idle();
		do
			@(negedge clk);
		while (pkt_q.size() != 0 || in_valid || frame_q.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Write merge_enable, then read it back.
	task automatic write_merge(input logic en);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= MERGE_EN_ADDR;
		pwdata <= {31'b0, en};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		merge_on = en;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		psel <= 1'b1;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== {31'b0, en}) begin
			$display("%0t: merge_enable readback mismatch, expected 0x%0h, actual 0x%0h",
				$time, {31'b0, en}, prdata);
			errors++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic cmp(input string fld, input logic [63:0] e, input logic [63:0] a);
		if (a !== e) begin
			$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, fld, e, a);
			errors++;
		end
	endtask

	task automatic check_frame();
		res_t r;
		if (frame_q.size() == 0) begin
			$display("%0t: frame beat with nothing expected, expected none, actual index %0d",
				$time, frame_index);
			errors++;
		end else begin
			r = frame_q.pop_front();
			cmp("frame_index", 64'(r.frame_index), 64'(frame_index));
			cmp("gop_index", 64'(r.gop_index), 64'(gop_index));
			cmp("out_pts", 64'(r.out_pts), 64'(out_pts));
			cmp("out_offset", 64'(r.out_offset), 64'(out_offset));
			cmp("out_size", 64'(r.out_size), 64'(out_size));
			cmp("out_type", 64'(r.out_type), 64'(out_type));
			cmp("out_keyframe", 64'(r.out_keyframe), 64'(out_keyframe));
			cmp("raw_index", 64'(r.raw_index), 64'(raw_index));
			cmp("fields_merged", 64'(r.fields_merged), 64'(fields_merged));
			cmp("last", 64'(r.last), 64'(last));
		end
	endtask

	// Packet driver: bursts of random length with random gaps between them.
	int burst_left = 0;
	int gap_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			burst_left <= 0;
			gap_left <= 0;
		end else begin
			if (in_valid && in_ready)
				predict_frames(in_pkt);
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (pkt_q.size() > 0) begin
					in_pkt <= pkt_q.pop_front();
					in_valid <= 1'b1;
					if (burst_left <= 1) begin
						// new burst; now and then a long one with no gap
						if ($urandom_range(0, 9) == 0) begin
							burst_left <= $urandom_range(100, 300);
							gap_left <= 0;
						end else begin
							burst_left <= $urandom_range(1, 24);
							gap_left <= ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
						end
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Frame monitor and receiver stall pattern.
	rx_mode_e rx_mode = RX_FREE;
	int mode_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_mode <= RX_FREE;
			mode_left <= 0;
		end else begin
			if (out_valid && out_ready)
				check_frame();
			if (mode_left == 0) begin
				rx_mode <= rx_mode_e'($urandom_range(0, 3));
				mode_left <= $urandom_range(32, 256);
			end else begin
				mode_left <= mode_left - 1;
			end
			case (rx_mode)
				RX_FREE: out_ready <= 1'b1;
				RX_COIN: out_ready <= 1'($urandom_range(0, 1));
				RX_SLOW: out_ready <= (cycles[1:0] == 2'b00);
				default: out_ready <= ($urandom_range(0, 9) != 0);
			endcase
		end
	end

	// Run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		item_t d;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// first frame is a keyframe with all-zero content; GOP must not step
		d = pkt(1'b0, 1'b0, 16'h0000, 1'b0);
		d.pts = '0;
		d.file_offset = '0;
		d.packet_size = '0;
		d.is_keyframe = 1'b1;
		d.frame_type = 2'd0;
		pkt_q.push_back(d);
		// top and bottom at full scale merge; sizes add past 24 bits
		d = pkt(1'b1, 1'b0, 16'hFFFF, 1'b0);
		d.pts = '1;
		d.file_offset = '1;
		d.packet_size = '1;
		d.is_keyframe = 1'b1;
		d.frame_type = 2'd2;
		pkt_q.push_back(d);
		d = pkt(1'b1, 1'b1, 16'hFFFF, 1'b0);
		d.pts = '0;
		d.packet_size = '1;
		d.is_keyframe = 1'b0;
		d.frame_type = 2'd1;
		pkt_q.push_back(d);
		// bottom with another frame number: two frames
		pkt_q.push_back(pkt(1'b1, 1'b0, 16'h1234, 1'b0));
		pkt_q.push_back(pkt(1'b1, 1'b1, 16'h1235, 1'b0));
		// top after top: first one flushed alone
		pkt_q.push_back(pkt(1'b1, 1'b0, 16'h0005, 1'b0));
		pkt_q.push_back(pkt(1'b1, 1'b0, 16'h0005, 1'b0));
		// end of stream on a progressive frame flushes the held top
		d = pkt(1'b0, 1'b0, 16'h0005, 1'b1);
		d.is_keyframe = 1'b1;
		pkt_q.push_back(d);
		// top with end of stream goes out alone
		pkt_q.push_back(pkt(1'b1, 1'b0, 16'h0006, 1'b1));
		// bottom with end of stream still merges
		pkt_q.push_back(pkt(1'b1, 1'b0, 16'h0007, 1'b0));
		pkt_q.push_back(pkt(1'b1, 1'b1, 16'h0007, 1'b1));
		// bottom with nothing held
		pkt_q.push_back(pkt(1'b1, 1'b1, 16'h00F0, 1'b0));
		// type code 3 passes through
		d = pkt(1'b0, 1'b0, 16'h0000, 1'b0);
		d.frame_type = 2'd3;
		pkt_q.push_back(d);
		// bottom flag without field coding never pairs
		pkt_q.push_back(pkt(1'b1, 1'b0, 16'h0009, 1'b0));
		pkt_q.push_back(pkt(1'b0, 1'b1, 16'h0009, 1'b0));
		// frame numbers differing only in the top bit
		d = pkt(1'b1, 1'b0, 16'h8000, 1'b0);
		d.is_keyframe = 1'b1;
		pkt_q.push_back(d);
		pkt_q.push_back(pkt(1'b1, 1'b1, 16'h0000, 1'b0));
		// leave a top field held across the register write
		pkt_q.push_back(pkt(1'b1, 1'b0, 16'h00AA, 1'b0));
		wait_idle();

		// merge off while a top is held: held top goes out, then its partner alone
		write_merge(1'b0);
		pkt_q.push_back(pkt(1'b1, 1'b1, 16'h00AA, 1'b0));
		pkt_q.push_back(pkt(1'b1, 1'b0, 16'h0001, 1'b0));
		gen_stream(300);
		wait_idle();

		write_merge(1'b1);
		gen_stream(900);
		wait_idle();

		write_merge(1'b0);
		gen_stream(200);
		wait_idle();

		write_merge(1'b1);
		gen_stream(600);
		pkt_q.push_back(pkt(1'b0, 1'b0, 16'h0000, 1'b1));
		wait_idle();

		repeat (DRAIN_CYCLES) @(negedge clk);
		if (errors == 0 && frame_q.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
